// File: hw/rtl/ypfc_pkg.sv
// ----------------------------------------------------------------------------
// ypfc_pkg
// Shared constants and the CORDIC arctangent table for the fly camera block.
// ----------------------------------------------------------------------------
package ypfc_pkg;

    // Angles in degrees with 8 fraction bits.
    localparam logic signed [17:0] HALF_TURN_Q8 = 18'sd46080;
    localparam logic signed [18:0] FULL_TURN_Q8 = 19'sd92160;

    // CORDIC angles in degrees with 16 fraction bits.
    localparam logic signed [25:0] RIGHT_ANGLE_Q16 = 26'sd5898240;
    localparam logic signed [25:0] HALF_TURN_Q16   = 26'sd11796480;

    // CORDIC start vector, Q.30.
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    // Reset values of the configuration registers.
    localparam logic [14:0] MAX_PITCH_RESET  = 15'd22784;
    localparam logic [15:0] MOVE_SPEED_RESET = 16'd2560;

    // Register indexes.
    localparam logic REG_MAX_PITCH  = 1'b0;
    localparam logic REG_MOVE_SPEED = 1'b1;

    // Arctangent of 2^-i in degrees Q.16, rounded to nearest.
    function automatic logic [21:0] ypfc_atan(input logic [4:0] idx);
        logic [21:0] r;
        case (idx)
            5'd0:  r = 22'd2949120;
            5'd1:  r = 22'd1740967;
            5'd2:  r = 22'd919879;
            5'd3:  r = 22'd466945;
            5'd4:  r = 22'd234379;
            5'd5:  r = 22'd117304;
            5'd6:  r = 22'd58666;
            5'd7:  r = 22'd29335;
            5'd8:  r = 22'd14668;
            5'd9:  r = 22'd7334;
            5'd10: r = 22'd3667;
            5'd11: r = 22'd1833;
            5'd12: r = 22'd917;
            5'd13: r = 22'd458;
            5'd14: r = 22'd229;
            5'd15: r = 22'd115;
            5'd16: r = 22'd57;
            5'd17: r = 22'd29;
            5'd18: r = 22'd14;
            5'd19: r = 22'd7;
            5'd20: r = 22'd4;
            5'd21: r = 22'd2;
            5'd22: r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/yaw_pitch_fly_camera_update_top.sv
// ----------------------------------------------------------------------------
// yaw_pitch_fly_camera_update_top
// Yaw/pitch free-fly camera: angle update, rotation matrix and position move.
// ----------------------------------------------------------------------------
// Each input transaction updates the stored yaw (wrapped into [-180, 180)
// degrees) and pitch (clamped to +-max_pitch), forms R = Rz(yaw) * Ry(pitch)
// in Q1.14 and moves the stored Q16.16 position along the forward, side and
// up columns of R, saturating at the position range. A transaction runs from
// its accept to its result through the angle update, the shared CORDIC stage
// for each of the two angles in turn, 17 multiplications on the one shared
// 18 x 35 multiplier, and the load of the output register. The input is not
// ready while a transaction is in work and is taken again in the cycle after
// the result is loaded. The finished result sits in an output register, so a
// new input transaction is taken while the previous result still waits.
// Configuration registers are to be written over the APB port only while
// idle; the block itself does not enforce this.
module yaw_pitch_fly_camera_update_top #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int POSITION_BITS     = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Input channel.
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [16:0] s_yaw_step,
    input  logic signed [16:0] s_pitch_step,
    input  logic [15:0]        s_ahead_amount,
    input  logic [15:0]        s_back_amount,
    input  logic [15:0]        s_leftward_amount,
    input  logic [15:0]        s_rightward_amount,
    input  logic [15:0]        s_upward_amount,
    input  logic [15:0]        s_downward_amount,
    input  logic [16:0]        s_time_step,
    // Result channel.
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_m00,
    output logic signed [15:0] m_m01,
    output logic signed [15:0] m_m02,
    output logic signed [15:0] m_m10,
    output logic signed [15:0] m_m11,
    output logic signed [15:0] m_m12,
    output logic signed [15:0] m_m20,
    output logic               m_m21,
    output logic signed [15:0] m_m22,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic signed [31:0] m_pos_z
);
    import ypfc_pkg::*;

    localparam int CW = $clog2(CORDIC_ITERATIONS);
    localparam int RW = ((POSITION_BITS > 34) ? POSITION_BITS : 34) + 1;
    localparam logic [CW-1:0] ITER_LAST = CW'(CORDIC_ITERATIONS - 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ANG   = 3'd1;
    localparam logic [2:0] S_CLOAD = 3'd2;
    localparam logic [2:0] S_CITER = 3'd3;
    localparam logic [2:0] S_CPOST = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // Multiplier schedule.
    localparam logic [4:0] MS_TSPEED = 5'd4;
    localparam logic [4:0] MS_TF     = 5'd5;
    localparam logic [4:0] MS_TU     = 5'd7;
    localparam logic [4:0] MS_LAST   = 5'd16;

    logic [2:0] state_reg, state_next;

    // Configuration registers and the APB port.
    logic [14:0] max_pitch_reg;
    logic [15:0] move_speed_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_MOVE_SPEED) ? {16'd0, move_speed_reg}
                                                 : {17'd0, max_pitch_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_pitch_reg  <= MAX_PITCH_RESET;
            move_speed_reg <= MOVE_SPEED_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_MAX_PITCH) begin
                max_pitch_reg <= pwdata[14:0];
            end else begin
                move_speed_reg <= pwdata[15:0];
            end
        end
    end

    // Latched input transaction.
    logic signed [16:0] yaw_step_reg, pitch_step_reg;
    logic signed [16:0] d_fwd_reg, d_side_reg, d_up_reg;
    logic [16:0]        time_reg;

    // Camera state.
    logic signed [16:0] yaw_reg, pitch_reg;
    logic signed [POSITION_BITS-1:0] px_reg, py_reg, pz_reg;

    // CORDIC datapath.
    logic signed [33:0] x_reg, y_reg;
    logic signed [25:0] z_reg;
    logic [CW-1:0]      iter_reg;
    logic               flip_reg;
    logic               sel_pitch_reg;
    logic signed [15:0] sy_reg, cy_reg, sp_reg, cp_reg;

    // Multiplier datapath.
    logic [4:0]         mstep_reg;
    logic               mphase_reg;
    logic signed [17:0] mul_a;
    logic signed [34:0] mul_b;
    logic signed [52:0] prod_reg;
    logic signed [34:0] tspeed_reg;
    logic signed [27:0] tf_reg, ts_reg, tu_reg;
    logic signed [47:0] acc_reg;
    logic signed [15:0] m00_reg, m02_reg, m10_reg, m12_reg;

    // Angle update: one wrap correction covers the whole step range.
    logic signed [18:0] yaw_sum, yaw_wrap, pitch_dif, lim_pos, lim_neg, pitch_clamp;

    always_comb begin
        yaw_sum = 19'(yaw_reg) + 19'(yaw_step_reg);
        if (yaw_sum >= 19'(HALF_TURN_Q8)) begin
            yaw_wrap = yaw_sum - FULL_TURN_Q8;
        end else if (yaw_sum < -19'(HALF_TURN_Q8)) begin
            yaw_wrap = yaw_sum + FULL_TURN_Q8;
        end else begin
            yaw_wrap = yaw_sum;
        end
        lim_pos   = $signed({4'd0, max_pitch_reg});
        lim_neg   = -lim_pos;
        pitch_dif = 19'(pitch_reg) - 19'(pitch_step_reg);
        if (pitch_dif > lim_pos) begin
            pitch_clamp = lim_pos;
        end else if (pitch_dif < lim_neg) begin
            pitch_clamp = lim_neg;
        end else begin
            pitch_clamp = pitch_dif;
        end
    end

    // CORDIC load with folding beyond +-90 degrees, and one rotation step.
    logic signed [16:0] angle_sel;
    logic signed [25:0] z_load;
    logic signed [33:0] dx, dy;
    logic signed [25:0] atan_val;
    logic signed [33:0] vx, vy;

    function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
        logic signed [17:0] t;
        logic signed [15:0] r;
        t = 18'((v + 34'sd32768) >>> 16);
        if (t > 18'(ONE_Q14)) begin
            r = ONE_Q14;
        end else if (t < -18'(ONE_Q14)) begin
            r = -ONE_Q14;
        end else begin
            r = 16'(t);
        end
        return r;
    endfunction

    always_comb begin
        angle_sel = sel_pitch_reg ? pitch_reg : yaw_reg;
        z_load    = {{1{angle_sel[16]}}, angle_sel, 8'd0};
        dx        = y_reg >>> iter_reg;
        dy        = x_reg >>> iter_reg;
        atan_val  = $signed({4'd0, ypfc_atan(5'(iter_reg))});
        vx        = flip_reg ? -x_reg : x_reg;
        vy        = flip_reg ? -y_reg : y_reg;
    end

    // Operand selection for the shared multiplier.
    logic signed [16:0] entry;
    logic signed [27:0] trav;

    always_comb begin
        case (mstep_reg)
            5'd8:    entry = 17'(m00_reg);
            5'd9:    entry = -17'(sy_reg);
            5'd10:   entry = 17'(m02_reg);
            5'd11:   entry = 17'(m10_reg);
            5'd12:   entry = 17'(cy_reg);
            5'd13:   entry = 17'(m12_reg);
            5'd14:   entry = -17'(sp_reg);
            5'd16:   entry = 17'(cp_reg);
            default: entry = 17'sd0;
        endcase
        case (mstep_reg)
            5'd8, 5'd11, 5'd14: trav = tf_reg;
            5'd9, 5'd12, 5'd15: trav = ts_reg;
            default:            trav = tu_reg;
        endcase
        case (mstep_reg)
            5'd0: begin
                mul_a = 18'(cy_reg);
                mul_b = 35'(cp_reg);
            end
            5'd1: begin
                mul_a = 18'(cy_reg);
                mul_b = 35'(sp_reg);
            end
            5'd2: begin
                mul_a = 18'(sy_reg);
                mul_b = 35'(cp_reg);
            end
            5'd3: begin
                mul_a = 18'(sy_reg);
                mul_b = 35'(sp_reg);
            end
            5'd4: begin
                mul_a = $signed({1'b0, time_reg});
                mul_b = $signed({19'd0, move_speed_reg});
            end
            5'd5: begin
                mul_a = 18'(d_fwd_reg);
                mul_b = tspeed_reg;
            end
            5'd6: begin
                mul_a = 18'(d_side_reg);
                mul_b = tspeed_reg;
            end
            5'd7: begin
                mul_a = 18'(d_up_reg);
                mul_b = tspeed_reg;
            end
            default: begin
                mul_a = 18'(entry);
                mul_b = 35'(trav);
            end
        endcase
    end

    // Result shaping of the registered product.
    logic signed [15:0] prod_q14;
    logic signed [27:0] prod_trav;
    logic signed [47:0] row_sum;
    logic signed [RW-1:0] pos_old, pos_new, pos_hi, pos_lo;
    logic signed [POSITION_BITS-1:0] pos_sat;
    logic               row_first, row_last;
    logic [1:0]         row;

    always_comb begin
        prod_q14  = 16'((prod_reg + 53'sd8192) >>> 14);
        prod_trav = 28'((prod_reg + 53'sd4194304) >>> 23);
        row_first = (mstep_reg == 5'd8) || (mstep_reg == 5'd11) || (mstep_reg == 5'd14);
        row_last  = (mstep_reg == 5'd10) || (mstep_reg == 5'd13) || (mstep_reg == 5'd16);
        row       = (mstep_reg <= 5'd10) ? 2'd0 : ((mstep_reg <= 5'd13) ? 2'd1 : 2'd2);
        row_sum   = (row_first ? 48'sd0 : acc_reg) + 48'(prod_reg);
        case (row)
            2'd0:    pos_old = RW'(px_reg);
            2'd1:    pos_old = RW'(py_reg);
            default: pos_old = RW'(pz_reg);
        endcase
        pos_hi  = (RW'(1) <<< (POSITION_BITS - 1)) - RW'(1);
        pos_lo  = -pos_hi - RW'(1);
        pos_new = pos_old + RW'((row_sum + 48'sd8192) >>> 14);
        if (pos_new > pos_hi) begin
            pos_sat = POSITION_BITS'(pos_hi);
        end else if (pos_new < pos_lo) begin
            pos_sat = POSITION_BITS'(pos_lo);
        end else begin
            pos_sat = POSITION_BITS'(pos_new);
        end
    end

    // Sequencer.
    logic out_free;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_valid) state_next = S_ANG;
            S_ANG:   state_next = S_CLOAD;
            S_CLOAD: state_next = S_CITER;
            S_CITER: if (iter_reg == ITER_LAST) state_next = S_CPOST;
            S_CPOST: state_next = sel_pitch_reg ? S_MUL : S_CLOAD;
            S_MUL:   if (mphase_reg && mstep_reg == MS_LAST) state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            yaw_reg       <= '0;
            pitch_reg     <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            pz_reg        <= '0;
            sel_pitch_reg <= 1'b0;
            iter_reg      <= '0;
            mstep_reg     <= '0;
            mphase_reg    <= 1'b0;
            m_valid       <= 1'b0;
        end else begin
            state_reg <= state_next;
            // A new result replaces the old one in the same cycle it leaves.
            if (state_reg == S_DONE && out_free) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        yaw_step_reg   <= s_yaw_step;
                        pitch_step_reg <= s_pitch_step;
                        d_fwd_reg      <= $signed({1'b0, s_ahead_amount})
                                          - $signed({1'b0, s_back_amount});
                        d_side_reg     <= $signed({1'b0, s_leftward_amount})
                                          - $signed({1'b0, s_rightward_amount});
                        d_up_reg       <= $signed({1'b0, s_upward_amount})
                                          - $signed({1'b0, s_downward_amount});
                        time_reg       <= s_time_step;
                    end
                end
                S_ANG: begin
                    yaw_reg       <= 17'(yaw_wrap);
                    pitch_reg     <= 17'(pitch_clamp);
                    sel_pitch_reg <= 1'b0;
                end
                S_CLOAD: begin
                    x_reg    <= CORDIC_GAIN_Q30;
                    y_reg    <= '0;
                    iter_reg <= '0;
                    if (z_load > RIGHT_ANGLE_Q16) begin
                        z_reg    <= z_load - HALF_TURN_Q16;
                        flip_reg <= 1'b1;
                    end else if (z_load < -RIGHT_ANGLE_Q16) begin
                        z_reg    <= z_load + HALF_TURN_Q16;
                        flip_reg <= 1'b1;
                    end else begin
                        z_reg    <= z_load;
                        flip_reg <= 1'b0;
                    end
                end
                S_CITER: begin
                    if (!z_reg[25]) begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - atan_val;
                    end else begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + atan_val;
                    end
                    iter_reg <= iter_reg + CW'(1);
                end
                S_CPOST: begin
                    if (sel_pitch_reg) begin
                        sp_reg <= to_q14(vy);
                        cp_reg <= to_q14(vx);
                    end else begin
                        sy_reg <= to_q14(vy);
                        cy_reg <= to_q14(vx);
                    end
                    sel_pitch_reg <= 1'b1;
                    mstep_reg     <= '0;
                    mphase_reg    <= 1'b0;
                end
                S_MUL: begin
                    mphase_reg <= !mphase_reg;
                    if (!mphase_reg) begin
                        prod_reg <= mul_a * mul_b;
                    end else begin
                        mstep_reg <= mstep_reg + 5'd1;
                        case (mstep_reg)
                            5'd0: m00_reg <= prod_q14;
                            5'd1: m02_reg <= prod_q14;
                            5'd2: m10_reg <= prod_q14;
                            5'd3: m12_reg <= prod_q14;
                            MS_TSPEED: tspeed_reg <= 35'(prod_reg);
                            MS_TF: tf_reg <= prod_trav;
                            5'd6:  ts_reg <= prod_trav;
                            MS_TU: tu_reg <= prod_trav;
                            default: begin
                                acc_reg <= row_sum;
                                if (row_last) begin
                                    case (row)
                                        2'd0:    px_reg <= pos_sat;
                                        2'd1:    py_reg <= pos_sat;
                                        default: pz_reg <= pos_sat;
                                    endcase
                                end
                            end
                        endcase
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        m_m00   <= m00_reg;
                        m_m01   <= -sy_reg;
                        m_m02   <= m02_reg;
                        m_m10   <= m10_reg;
                        m_m11   <= cy_reg;
                        m_m12   <= m12_reg;
                        m_m20   <= -sp_reg;
                        m_m22   <= cp_reg;
                        m_pos_x <= 32'(RW'(px_reg));
                        m_pos_y <= 32'(RW'(py_reg));
                        m_pos_z <= 32'(RW'(pz_reg));
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_m21 = 1'b0;

endmodule

// File: hw/rtl/ypfc_checker.sv
// ----------------------------------------------------------------------------
// ypfc_checker
// Port-level assertions for the fly camera block, bound to the top level.
// ----------------------------------------------------------------------------
module ypfc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_m11,
    input logic               m_m21,
    input logic signed [31:0] m_pos_x
);
    import ypfc_pkg::*;

    // A stalled result transaction keeps its position.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pos_x))
        else $error("result changed while stalled");

    // The block is busy right after it takes an input transaction.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after accept");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_m21 == 1'b0)
        else $error("m21 not zero");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_m11 <= ONE_Q14) && (m_m11 >= -ONE_Q14))
        else $error("m11 out of Q1.14 range");

endmodule

bind yaw_pitch_fly_camera_update_top ypfc_checker u_ypfc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_m11   (m_m11),
    .m_m21   (m_m21),
    .m_pos_x (m_pos_x)
);
